/* rtl/otrc_pkg.sv */
// ----------------------------------------------------------------------------
// otrc_pkg
// Shared constants, types and helpers of the occupancy transition rate cell.
// ----------------------------------------------------------------------------
package otrc_pkg;

    localparam int PROB_BITS = 16;
    localparam int EV_W      = 32;
    localparam int RUN_W     = 24;
    localparam int TS_W      = 32;
    localparam int CNT_W     = $clog2(EV_W + 1);

    localparam logic [PROB_BITS:0] P_ONE  = (PROB_BITS + 1)'(1) << PROB_BITS;
    localparam logic [PROB_BITS:0] P_HALF = (PROB_BITS + 1)'(1) << (PROB_BITS - 1);

    localparam int IN_W  = PROB_BITS + TS_W;
    localparam int IN_TW = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W = 4 * (PROB_BITS + 1) + TS_W + EV_W + 1;
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

    typedef enum logic [4:0] {
        S_IDLE, S_EVID, S_HIST_GO, S_HIST_WAIT, S_RUN_GO, S_RUN_WAIT, S_CLOSE,
        S_ACCUM, S_MUL, S_EST, S_ER_GO, S_ER_WAIT, S_XR_GO, S_XR_WAIT,
        S_LT_GO, S_LT_WAIT, S_DONE
    } t_state;

    typedef enum logic [2:0] {
        DS_HIST, DS_RUN, DS_ER, DS_XR, DS_LT
    } t_div_sel;

    typedef struct packed {
        logic     load;
        logic     evid;
        logic     close;
        logic     accum;
        logic     mul;
        logic     est;
        logic     out_load;
        logic     div_start;
        logic     div_cap;
        t_div_sel div_sel;
    } t_cmd;

    typedef struct packed {
        logic trans;
        logic div_done;
        logic out_free;
    } t_stat;

    function automatic logic [EV_W-1:0] sat_ev(input logic [EV_W-1:0] a,
                                               input logic [EV_W-1:0] b);
        logic [EV_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[EV_W] ? {EV_W{1'b1}} : s[EV_W-1:0];
    endfunction

    function automatic logic [RUN_W-1:0] sat_run(input logic [RUN_W-1:0] a);
        return (a == {RUN_W{1'b1}}) ? a : a + RUN_W'(1);
    endfunction

endpackage

/* rtl/otrc_div.sv */
// ----------------------------------------------------------------------------
// otrc_div
// Shared restoring divider, one quotient bit per cycle, integer or fraction.
// ----------------------------------------------------------------------------
module otrc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_frac,
    input  logic [otrc_pkg::EV_W-1:0]     i_num,
    input  logic [otrc_pkg::EV_W-1:0]     i_den,
    output logic                          o_done,
    output logic [otrc_pkg::EV_W-1:0]     o_quo
);

    logic                           r_busy;
    logic                           r_done;
    logic [otrc_pkg::CNT_W-1:0]     r_cnt;
    logic [otrc_pkg::EV_W-1:0]      r_rem;
    logic [otrc_pkg::EV_W-1:0]      r_dvd;
    logic [otrc_pkg::EV_W-1:0]      r_quo;
    logic [otrc_pkg::EV_W-1:0]      r_den;
    logic [otrc_pkg::EV_W:0]        n_rem2;
    logic                           n_ge;
    logic                           n_quick;

    assign n_rem2  = {r_rem, r_dvd[otrc_pkg::EV_W-1]};
    assign n_ge    = n_rem2 >= {1'b0, r_den};
    assign n_quick = (i_den == '0) || (i_frac && i_num >= i_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_done <= n_quick;
                if (!n_quick) begin
                    r_busy <= 1'b1;
                    r_cnt  <= i_frac ? otrc_pkg::CNT_W'(otrc_pkg::PROB_BITS)
                                     : otrc_pkg::CNT_W'(otrc_pkg::EV_W);
                end
            end else if (r_busy) begin
                r_cnt  <= r_cnt - otrc_pkg::CNT_W'(1);
                r_done <= (r_cnt == otrc_pkg::CNT_W'(1));
                if (r_cnt == otrc_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= i_frac ? i_num : '0;
            r_dvd <= i_frac ? '0 : i_num;
            if (i_den == '0) begin
                r_quo <= '0;
            end else if (i_frac && i_num >= i_den) begin
                r_quo <= otrc_pkg::EV_W'(otrc_pkg::P_ONE);
            end else begin
                r_quo <= '0;
            end
        end else if (r_busy) begin
            r_rem <= n_ge ? n_rem2[otrc_pkg::EV_W-1:0] - r_den
                          : n_rem2[otrc_pkg::EV_W-1:0];
            r_dvd <= {r_dvd[otrc_pkg::EV_W-2:0], 1'b0};
            r_quo <= {r_quo[otrc_pkg::EV_W-2:0], n_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

/* rtl/otrc_dp.sv */
// ----------------------------------------------------------------------------
// otrc_dp
// Datapath: cell state, evidence and run arithmetic, estimate, output register.
// ----------------------------------------------------------------------------
module otrc_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  otrc_pkg::t_cmd                 i_cmd,
    output otrc_pkg::t_stat                o_stat,
    input  logic [otrc_pkg::IN_TW-1:0]     i_s_tdata,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [otrc_pkg::OUT_TW-1:0]    o_m_tdata
);

    localparam int PB = otrc_pkg::PROB_BITS;
    localparam int EW = otrc_pkg::EV_W;
    localparam int RW = otrc_pkg::RUN_W;
    localparam int TW = otrc_pkg::TS_W;

    logic [PB-1:0]   r_occ;
    logic [TW-1:0]   r_ts;
    logic [PB:0]     r_w;
    logic            r_is_occ;
    logic            r_trans;

    logic [EW-1:0]   r_occ_ev, r_free_ev, r_entry_tot, r_exit_tot;
    logic [PB-1:0]   r_prev;
    logic [PB:0]     r_est;
    logic [EW-1:0]   r_run_en_res, r_run_ex_res, r_hist_en_res, r_hist_ex_res;
    logic [RW-1:0]   r_run_en_len, r_run_ex_len, r_hist_en_len, r_hist_ex_len;
    logic [TW-1:0]   r_last;

    logic [EW-1:0]   r_old_avg, r_cur_avg;
    logic [2*PB+1:0] r_prod;
    logic            r_neg;
    logic [PB:0]     r_er, r_xr, r_lt;

    logic            r_m_valid;
    logic [PB:0]     r_o_er, r_o_xr, r_o_lt, r_o_est;
    logic [TW-1:0]   r_o_tt;
    logic [EW:0]     r_o_ev;

    logic [PB-1:0]   n_occ;
    logic            n_is_occ;
    logic [EW-1:0]   n_w_ev;
    logic [EW-1:0]   n_credit;
    logic [EW-1:0]   n_div_num, n_div_den;
    logic            n_div_frac;
    logic            w_div_done;
    logic [EW-1:0]   w_div_quo;
    logic [PB:0]     n_occ_x, n_mag;
    logic [2*PB+1:0] n_round;
    logic [PB+1:0]   n_q;
    logic [PB+2:0]   n_up;

    assign n_occ    = i_s_tdata[PB-1:0];
    assign n_is_occ = {1'b0, n_occ} > otrc_pkg::P_HALF;
    assign n_w_ev   = EW'(r_w);
    assign n_occ_x  = {1'b0, r_occ};

    always_comb begin
        if (r_is_occ) begin
            n_credit = (n_w_ev < r_run_en_res) ? n_w_ev : r_run_en_res;
        end else begin
            n_credit = (n_w_ev < r_run_ex_res) ? n_w_ev : r_run_ex_res;
        end
    end

    always_comb begin
        n_div_frac = 1'b1;
        n_div_num  = '0;
        n_div_den  = '0;
        unique case (i_cmd.div_sel)
            otrc_pkg::DS_HIST: begin
                n_div_frac = 1'b0;
                n_div_num  = r_is_occ ? r_hist_en_res : r_hist_ex_res;
                n_div_den  = EW'(r_is_occ ? r_hist_en_len : r_hist_ex_len);
            end
            otrc_pkg::DS_RUN: begin
                n_div_frac = 1'b0;
                n_div_num  = r_is_occ ? r_run_en_res : r_run_ex_res;
                n_div_den  = EW'(r_is_occ ? r_run_en_len : r_run_ex_len);
            end
            otrc_pkg::DS_ER: begin
                n_div_num = r_entry_tot;
                n_div_den = r_free_ev;
            end
            otrc_pkg::DS_XR: begin
                n_div_num = r_exit_tot;
                n_div_den = r_occ_ev;
            end
            otrc_pkg::DS_LT: begin
                n_div_num = EW'(r_er);
                n_div_den = EW'({1'b0, r_er} + {1'b0, r_xr});
            end
            default: begin
                n_div_num = '0;
            end
        endcase
    end

    otrc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_frac  (n_div_frac),
        .i_num   (n_div_num),
        .i_den   (n_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    assign n_mag   = (n_occ_x < r_est) ? r_est - n_occ_x : n_occ_x - r_est;
    assign n_round = r_prod + (2*PB+2)'(otrc_pkg::P_HALF);
    assign n_q     = n_round[2*PB+1:PB];
    assign n_up    = (PB+3)'(r_est) + (PB+3)'(n_q);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_occ    <= n_occ;
            r_ts     <= i_s_tdata[PB+TW-1:PB];
            r_is_occ <= n_is_occ;
            r_w      <= n_is_occ ? ({1'b0, n_occ} - otrc_pkg::P_HALF) << 1
                                 : (otrc_pkg::P_HALF - {1'b0, n_occ}) << 1;
            r_trans  <= n_is_occ ? ({1'b0, r_prev} <= otrc_pkg::P_HALF)
                                 : ({1'b0, r_prev} >  otrc_pkg::P_HALF);
        end
        if (i_cmd.div_cap && w_div_done) begin
            unique case (i_cmd.div_sel)
                otrc_pkg::DS_HIST: r_old_avg <= w_div_quo;
                otrc_pkg::DS_RUN:  r_cur_avg <= w_div_quo;
                otrc_pkg::DS_ER:   r_er      <= w_div_quo[PB:0];
                otrc_pkg::DS_XR:   r_xr      <= w_div_quo[PB:0];
                otrc_pkg::DS_LT:   r_lt      <= w_div_quo[PB:0];
                default:           r_lt      <= r_lt;
            endcase
        end
        if (i_cmd.mul) begin
            r_prod <= r_w * n_mag;
            r_neg  <= n_occ_x < r_est;
        end
        if (i_cmd.out_load) begin
            r_o_er  <= r_er;
            r_o_xr  <= r_xr;
            r_o_lt  <= r_lt;
            r_o_est <= r_est;
            r_o_tt  <= r_last;
            r_o_ev  <= {1'b0, r_free_ev} + {1'b0, r_occ_ev};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ_ev      <= EW'(1);
            r_free_ev     <= EW'(1);
            r_entry_tot   <= EW'(1);
            r_exit_tot    <= EW'(1);
            r_prev        <= PB'(otrc_pkg::P_HALF);
            r_est         <= otrc_pkg::P_HALF;
            r_run_en_res  <= '0;
            r_run_ex_res  <= '0;
            r_hist_en_res <= '0;
            r_hist_ex_res <= '0;
            r_run_en_len  <= '0;
            r_run_ex_len  <= '0;
            r_hist_en_len <= '0;
            r_hist_ex_len <= '0;
            r_last        <= '0;
            r_m_valid     <= 1'b0;
        end else begin
            if (i_cmd.out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            if (i_cmd.evid) begin
                r_prev <= r_occ;
                if (r_is_occ) begin
                    r_occ_ev <= otrc_pkg::sat_ev(r_occ_ev, n_w_ev);
                    if (r_trans) begin
                        r_run_ex_res <= '0;
                        r_run_ex_len <= '0;
                        r_last       <= r_ts;
                    end
                end else begin
                    r_free_ev <= otrc_pkg::sat_ev(r_free_ev, n_w_ev);
                    if (r_trans) begin
                        r_run_en_res <= '0;
                        r_run_en_len <= '0;
                        r_last       <= r_ts;
                    end
                end
            end
            if (i_cmd.close) begin
                if (r_is_occ) begin
                    if (r_cur_avg > r_old_avg) begin
                        r_run_en_res  <= r_cur_avg;
                        r_hist_en_res <= '0;
                        r_hist_en_len <= '0;
                    end else begin
                        r_run_en_res  <= r_old_avg;
                    end
                end else begin
                    if (r_cur_avg > r_old_avg) begin
                        r_run_ex_res  <= r_cur_avg;
                        r_hist_ex_res <= '0;
                        r_hist_ex_len <= '0;
                    end else begin
                        r_run_ex_res  <= r_old_avg;
                    end
                end
            end
            if (i_cmd.accum) begin
                if (r_is_occ) begin
                    r_run_ex_res  <= otrc_pkg::sat_ev(r_run_ex_res, n_w_ev);
                    r_run_ex_len  <= otrc_pkg::sat_run(r_run_ex_len);
                    r_hist_ex_res <= otrc_pkg::sat_ev(r_hist_ex_res, n_w_ev);
                    r_hist_ex_len <= otrc_pkg::sat_run(r_hist_ex_len);
                    r_entry_tot   <= otrc_pkg::sat_ev(r_entry_tot, n_credit);
                    r_run_en_res  <= r_run_en_res - n_credit;
                    r_hist_en_res <= (r_hist_en_res > n_credit)
                                     ? r_hist_en_res - n_credit : '0;
                end else begin
                    r_run_en_res  <= otrc_pkg::sat_ev(r_run_en_res, n_w_ev);
                    r_run_en_len  <= otrc_pkg::sat_run(r_run_en_len);
                    r_hist_en_res <= otrc_pkg::sat_ev(r_hist_en_res, n_w_ev);
                    r_hist_en_len <= otrc_pkg::sat_run(r_hist_en_len);
                    r_exit_tot    <= otrc_pkg::sat_ev(r_exit_tot, n_credit);
                    r_run_ex_res  <= r_run_ex_res - n_credit;
                    r_hist_ex_res <= (r_hist_ex_res > n_credit)
                                     ? r_hist_ex_res - n_credit : '0;
                end
            end
            if (i_cmd.est) begin
                if (r_neg) begin
                    r_est <= ((PB+2)'(r_est) < n_q) ? '0 : r_est - n_q[PB:0];
                end else if (n_up > (PB+3)'(otrc_pkg::P_ONE)) begin
                    r_est <= otrc_pkg::P_ONE;
                end else begin
                    r_est <= n_up[PB:0];
                end
            end
        end
    end

    assign o_stat.trans    = r_trans;
    assign o_stat.div_done = w_div_done;
    assign o_stat.out_free = !r_m_valid || i_m_tready;

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = otrc_pkg::OUT_TW'({r_o_ev, r_o_tt, r_o_est, r_o_lt, r_o_xr, r_o_er});

endmodule

/* rtl/otrc_ctrl.sv */
// ----------------------------------------------------------------------------
// otrc_ctrl
// Controller: sequences one observation through the datapath steps.
// ----------------------------------------------------------------------------
module otrc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  otrc_pkg::t_stat  i_stat,
    output otrc_pkg::t_cmd   o_cmd
);

    otrc_pkg::t_state r_state;
    otrc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= otrc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            otrc_pkg::S_IDLE:      if (i_s_tvalid) n_state = otrc_pkg::S_EVID;
            otrc_pkg::S_EVID:      n_state = i_stat.trans ? otrc_pkg::S_HIST_GO
                                                          : otrc_pkg::S_ACCUM;
            otrc_pkg::S_HIST_GO:   n_state = otrc_pkg::S_HIST_WAIT;
            otrc_pkg::S_HIST_WAIT: if (i_stat.div_done) n_state = otrc_pkg::S_RUN_GO;
            otrc_pkg::S_RUN_GO:    n_state = otrc_pkg::S_RUN_WAIT;
            otrc_pkg::S_RUN_WAIT:  if (i_stat.div_done) n_state = otrc_pkg::S_CLOSE;
            otrc_pkg::S_CLOSE:     n_state = otrc_pkg::S_ACCUM;
            otrc_pkg::S_ACCUM:     n_state = otrc_pkg::S_MUL;
            otrc_pkg::S_MUL:       n_state = otrc_pkg::S_EST;
            otrc_pkg::S_EST:       n_state = otrc_pkg::S_ER_GO;
            otrc_pkg::S_ER_GO:     n_state = otrc_pkg::S_ER_WAIT;
            otrc_pkg::S_ER_WAIT:   if (i_stat.div_done) n_state = otrc_pkg::S_XR_GO;
            otrc_pkg::S_XR_GO:     n_state = otrc_pkg::S_XR_WAIT;
            otrc_pkg::S_XR_WAIT:   if (i_stat.div_done) n_state = otrc_pkg::S_LT_GO;
            otrc_pkg::S_LT_GO:     n_state = otrc_pkg::S_LT_WAIT;
            otrc_pkg::S_LT_WAIT:   if (i_stat.div_done) n_state = otrc_pkg::S_DONE;
            otrc_pkg::S_DONE:      if (i_stat.out_free) n_state = otrc_pkg::S_IDLE;
            default:               n_state = otrc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.div_sel = otrc_pkg::DS_HIST;
        o_s_tready    = 1'b0;
        unique case (r_state)
            otrc_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            otrc_pkg::S_EVID:      o_cmd.evid = 1'b1;
            otrc_pkg::S_HIST_GO:   o_cmd.div_start = 1'b1;
            otrc_pkg::S_HIST_WAIT: o_cmd.div_cap = 1'b1;
            otrc_pkg::S_RUN_GO: begin
                o_cmd.div_sel   = otrc_pkg::DS_RUN;
                o_cmd.div_start = 1'b1;
            end
            otrc_pkg::S_RUN_WAIT: begin
                o_cmd.div_sel = otrc_pkg::DS_RUN;
                o_cmd.div_cap = 1'b1;
            end
            otrc_pkg::S_CLOSE:     o_cmd.close = 1'b1;
            otrc_pkg::S_ACCUM:     o_cmd.accum = 1'b1;
            otrc_pkg::S_MUL:       o_cmd.mul = 1'b1;
            otrc_pkg::S_EST:       o_cmd.est = 1'b1;
            otrc_pkg::S_ER_GO: begin
                o_cmd.div_sel   = otrc_pkg::DS_ER;
                o_cmd.div_start = 1'b1;
            end
            otrc_pkg::S_ER_WAIT: begin
                o_cmd.div_sel = otrc_pkg::DS_ER;
                o_cmd.div_cap = 1'b1;
            end
            otrc_pkg::S_XR_GO: begin
                o_cmd.div_sel   = otrc_pkg::DS_XR;
                o_cmd.div_start = 1'b1;
            end
            otrc_pkg::S_XR_WAIT: begin
                o_cmd.div_sel = otrc_pkg::DS_XR;
                o_cmd.div_cap = 1'b1;
            end
            otrc_pkg::S_LT_GO: begin
                o_cmd.div_sel   = otrc_pkg::DS_LT;
                o_cmd.div_start = 1'b1;
            end
            otrc_pkg::S_LT_WAIT: begin
                o_cmd.div_sel = otrc_pkg::DS_LT;
                o_cmd.div_cap = 1'b1;
            end
            otrc_pkg::S_DONE:      o_cmd.out_load = i_stat.out_free;
            default:               o_cmd = '0;
        endcase
    end

endmodule

/* rtl/occupancy_transition_rate_cell_unit.sv */
// ----------------------------------------------------------------------------
// occupancy_transition_rate_cell_unit
// Top level of one grid cell that tracks occupancy transition rates.
// ----------------------------------------------------------------------------
// The slave channel takes one observation per beat: an occupancy probability
// and a timestamp. The master channel returns one result beat per observation
// with the entry and exit rates, the long-term occupancy, the running
// estimate, the last transition time and the evidence total.
// One observation is processed at a time. Three fraction divisions on the
// shared bit-serial divider set the pace. An observation that flips the
// occupied/free state first needs two 32-bit run average divisions on the
// same divider. The result sits in an output register; the slave side is
// ready again as soon as the result is loaded. When the receiver stalls, the
// next result is held in the datapath and the controller waits, with the
// slave side not ready, until the output register frees up.
// Reset is synchronous and active low; it restores the cell state to its
// initial values and drops the output valid.
// ----------------------------------------------------------------------------
module occupancy_transition_rate_cell_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // Fields from bit 0: occupancy probability, timestamp.
    input  logic [otrc_pkg::IN_TW-1:0]      i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // Fields from bit 0: entry_rate, exit_rate, long_term_prob,
    // estimated_prob, transition_time, evidence_total.
    output logic [otrc_pkg::OUT_TW-1:0]     o_m_tdata
);

    otrc_pkg::t_cmd  w_cmd;
    otrc_pkg::t_stat w_stat;

    otrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    otrc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

`ifndef ASSERT_OFF
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("accepted a second observation while one is in flight");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_stat.out_free)
        else $error("result loaded over an untaken result");

    a_est_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[67:51] <= 17'd65536))
        else $error("estimate above one");
`endif

endmodule
